@@ hw/rtl/qic_pkg.sv @@
// qic_pkg: shared constants for the quad invertibility check block
// (index tables for sides and cross products, tolerance and register-port sizes)
// no dependencies
`default_nettype none

package qic_pkg;

    // coordinate width used when the top level is not overridden
    localparam int COORD_BITS_DEF = 24;

    localparam int NUM_CORNERS = 4;
    localparam int NUM_AXES    = 3;
    localparam int NUM_FIELDS  = NUM_CORNERS * NUM_AXES;
    localparam int NUM_CROSS   = 3;
    // dot products: midpoint magnitude, then the four corner jacobians
    localparam int NUM_DOTS    = 5;
    localparam int NUM_CORNER_DOTS = NUM_DOTS - 1;
    localparam int NUM_STAGES  = 8;

    // side k runs from corner k to corner SIDE_TO[k]
    localparam int SIDE_TO [NUM_CORNERS] = '{1, 2, 3, 0};

    // cyclic axis order used by the cross product
    localparam int AXIS_NEXT1 [NUM_AXES] = '{1, 2, 0};
    localparam int AXIS_NEXT2 [NUM_AXES] = '{2, 0, 1};

    // v1 = s3 x s0, v2 = s2 x s0, v3 = s3 x s1
    localparam int CROSS_LHS [NUM_CROSS] = '{3, 2, 3};
    localparam int CROSS_RHS [NUM_CROSS] = '{0, 0, 1};

    // tolerance register and its square
    localparam int TOL_BITS = 48;
    localparam int TOL_HALF = TOL_BITS / 2;
    localparam int LIM_BITS = 2 * TOL_BITS + 2;

    // register port
    localparam int APB_DATA_BITS   = 64;
    localparam int APB_ADDR_BITS   = 4;
    localparam int REG_STRIDE_LOG2 = 3;
    localparam int REG_IDX_BITS    = APB_ADDR_BITS - REG_STRIDE_LOG2;
    localparam logic [REG_IDX_BITS-1:0] REG_TOLERANCE = '0;

    // result word
    localparam int OUT_TDATA_BITS = 8;

endpackage

`default_nettype wire

@@ hw/rtl/quad_invertibility_check_top.sv @@
// quad_invertibility_check_top: pipelined sign check of a bilinear quad's jacobian
// depends on qic_pkg for index tables, tolerance and register-port sizes
`default_nettype none

// Checks whether a bilinear quadrilateral, given by its four corners p0..p3 in
// signed fixed point, is invertible. Side vectors s0..s3 give the cross products
// v1 = s3 x s0, v2 = s2 x s0 and v3 = s3 x s1, and the doubled midpoint normal
// m = 2*v1 + v2 + v3. When |m|^2 <= 4*tol^2 the element is reported as a
// degenerate midpoint and not invertible; otherwise it is invertible when m.v1,
// m.(v1+v3), m.(v1+v2) and m.(v1+v2+v3) are all strictly positive or all
// strictly negative. All arithmetic is exact, with no rounding or saturation.
// The datapath is an eight-stage pipeline that takes one word per clock while
// the output is not stalled; a result passes through stages 1 to 7 into the
// output register of stage 8 and is held there until m_tready takes it. Each
// stage holds its data while the stage after it is full and stalled, so
// bubbles are squeezed out and s_tready follows m_tready combinationally
// through the stage valid bits. The wide dot products are split into
// half-width partial products: one stage multiplies, one stage recombines,
// one stage sums the three axes. The tolerance register feeds a separate
// two-stage squaring path, partial products and then the limit register, so
// a new value reaches the limit register before any later word reaches the
// compare.
module quad_invertibility_check_top #(
    parameter int COORD_BITS = qic_pkg::COORD_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,

    // input words
    input  wire logic                       s_tvalid,
    output      logic                       s_tready,
    // p0_x, p0_y, p0_z, p1_x, ... p3_z from bit 0 up, COORD_BITS each, zero pad
    input  wire logic [((qic_pkg::NUM_FIELDS * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,

    // result words
    output      logic                                  m_tvalid,
    input  wire logic                                  m_tready,
    // bit 0 invertible, bit 1 degenerate_midpoint, zero pad
    output      logic [qic_pkg::OUT_TDATA_BITS-1:0]    m_tdata,

    // register port
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [qic_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  wire logic [qic_pkg::APB_DATA_BITS-1:0]     pwdata,
    output      logic [qic_pkg::APB_DATA_BITS-1:0]     prdata,
    output      logic                                  pready
);

    // widths of the datapath, all derived from the coordinate width
    localparam int C     = COORD_BITS;
    localparam int SW    = C + 1;                 // side vector component
    localparam int PW    = 2 * SW;                // cross product term
    localparam int VW    = PW + 1;                // cross product component
    localparam int MW    = VW + 2;                // midpoint and corner sums
    localparam int H     = (MW + 1) / 2;          // low half, unsigned
    localparam int HW    = MW - H;                // high half, signed
    localparam int LL_W  = 2 * H;
    localparam int MIX_W = H + 1 + HW;
    localparam int HH_W  = 2 * HW;
    localparam int DW    = 2 * MW;                // one axis of a dot product
    localparam int SUMW  = DW + 2;                // full dot product
    localparam int LIMW  = qic_pkg::LIM_BITS;
    localparam int CMPW  = (SUMW > LIMW) ? SUMW : LIMW;
    localparam int NST   = qic_pkg::NUM_STAGES;
    localparam int NCO   = qic_pkg::NUM_CORNERS;
    localparam int NAX   = qic_pkg::NUM_AXES;
    localparam int NCR   = qic_pkg::NUM_CROSS;
    localparam int NDOT  = qic_pkg::NUM_DOTS;
    localparam int NCD   = qic_pkg::NUM_CORNER_DOTS;
    localparam int TOLW  = qic_pkg::TOL_BITS;
    localparam int TOLH  = qic_pkg::TOL_HALF;
    localparam int DATAW = qic_pkg::APB_DATA_BITS;
    localparam int OUTW  = qic_pkg::OUT_TDATA_BITS;
    localparam int RIDXW = qic_pkg::REG_IDX_BITS;
    localparam int RSTR  = qic_pkg::REG_STRIDE_LOG2;

    // ------------------------------------------------------------------
    // register port: tolerance register and its squaring path
    // ------------------------------------------------------------------
    logic [RIDXW-1:0] reg_idx;
    logic             cfg_wr;
    logic [TOLW-1:0]  tol_reg;
    logic [TOLW-1:0]  tol_ll_reg, tol_lh_reg, tol_hh_reg;
    logic [TOLW-1:0]  tol_ll_next, tol_lh_next, tol_hh_next;
    logic [LIMW-1:0]  lim_reg;
    logic [LIMW-1:0]  lim_next;

    assign pready  = 1'b1;
    assign reg_idx = paddr[qic_pkg::APB_ADDR_BITS-1:RSTR];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (reg_idx == qic_pkg::REG_TOLERANCE) ? DATAW'(tol_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
        end
        else if (cfg_wr && (reg_idx == qic_pkg::REG_TOLERANCE))
        begin
            tol_reg <= pwdata[TOLW-1:0];
        end
    end

    // tol^2 from three half-width products, then 4*tol^2
    assign tol_ll_next = tol_reg[TOLH-1:0]    * tol_reg[TOLH-1:0];
    assign tol_lh_next = tol_reg[TOLH-1:0]    * tol_reg[TOLW-1:TOLH];
    assign tol_hh_next = tol_reg[TOLW-1:TOLH] * tol_reg[TOLW-1:TOLH];
    assign lim_next    = (LIMW'(tol_hh_reg) << (2 * TOLH + 2))
                       + (LIMW'(tol_lh_reg) << (TOLH + 3))
                       + (LIMW'(tol_ll_reg) << 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_ll_reg <= '0;
            tol_lh_reg <= '0;
            tol_hh_reg <= '0;
            lim_reg    <= '0;
        end
        else
        begin
            tol_ll_reg <= tol_ll_next;
            tol_lh_reg <= tol_lh_next;
            tol_hh_reg <= tol_hh_next;
            lim_reg    <= lim_next;
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: a stage loads when it is empty or the next one moves
    // ------------------------------------------------------------------
    logic [NST:1] vld_reg;
    logic [NST:1] vld_next;
    logic [NST:1] adv;

    always_comb
    begin
        adv[NST] = !vld_reg[NST] || m_tready;
        for (int k = NST - 1; k >= 1; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k + 1];
        end
    end

    always_comb
    begin
        vld_next[1] = adv[1] ? s_tvalid : vld_reg[1];
        for (int k = 2; k <= NST; k++)
        begin
            vld_next[k] = adv[k] ? vld_reg[k - 1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = adv[1];
    assign m_tvalid = vld_reg[NST];

    // ------------------------------------------------------------------
    // stage 1: side vectors
    // ------------------------------------------------------------------
    logic signed [SW-1:0] side_reg  [NCO][NAX];
    logic signed [SW-1:0] side_next [NCO][NAX];

    for (genvar k = 0; k < NCO; k++)
    begin : g_side
        for (genvar a = 0; a < NAX; a++)
        begin : g_axis
            logic signed [C-1:0] from_c;
            logic signed [C-1:0] to_c;
            assign from_c = s_tdata[(k * NAX + a) * C +: C];
            assign to_c   = s_tdata[(qic_pkg::SIDE_TO[k] * NAX + a) * C +: C];
            assign side_next[k][a] = SW'(to_c) - SW'(from_c);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            side_reg <= side_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: cross product terms
    // ------------------------------------------------------------------
    logic signed [PW-1:0] prod_reg  [NCR][NAX][2];
    logic signed [PW-1:0] prod_next [NCR][NAX][2];

    for (genvar c = 0; c < NCR; c++)
    begin : g_cross
        for (genvar j = 0; j < NAX; j++)
        begin : g_comp
            assign prod_next[c][j][0] =
                side_reg[qic_pkg::CROSS_LHS[c]][qic_pkg::AXIS_NEXT1[j]]
              * side_reg[qic_pkg::CROSS_RHS[c]][qic_pkg::AXIS_NEXT2[j]];
            assign prod_next[c][j][1] =
                side_reg[qic_pkg::CROSS_LHS[c]][qic_pkg::AXIS_NEXT2[j]]
              * side_reg[qic_pkg::CROSS_RHS[c]][qic_pkg::AXIS_NEXT1[j]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            prod_reg <= prod_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: v1, v2, v3
    // ------------------------------------------------------------------
    logic signed [VW-1:0] v_reg  [NCR][NAX];
    logic signed [VW-1:0] v_next [NCR][NAX];

    for (genvar c = 0; c < NCR; c++)
    begin : g_vec
        for (genvar j = 0; j < NAX; j++)
        begin : g_comp
            assign v_next[c][j] = VW'(prod_reg[c][j][0]) - VW'(prod_reg[c][j][1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            v_reg <= v_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: doubled midpoint normal and the four corner normals
    // ------------------------------------------------------------------
    logic signed [MW-1:0] m_reg  [NAX];
    logic signed [MW-1:0] m_next [NAX];
    logic signed [MW-1:0] w_reg  [NCD][NAX];
    logic signed [MW-1:0] w_next [NCD][NAX];

    for (genvar j = 0; j < NAX; j++)
    begin : g_sum
        logic signed [MW-1:0] v1;
        logic signed [MW-1:0] v2;
        logic signed [MW-1:0] v3;
        assign v1 = MW'(v_reg[0][j]);
        assign v2 = MW'(v_reg[1][j]);
        assign v3 = MW'(v_reg[2][j]);
        assign m_next[j]    = (v1 <<< 1) + v2 + v3;
        assign w_next[0][j] = v1;
        assign w_next[1][j] = v1 + v3;
        assign w_next[2][j] = v1 + v2;
        assign w_next[3][j] = v1 + v2 + v3;
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            m_reg <= m_next;
            w_reg <= w_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: half-width partial products of each dot product axis
    // dot 0 is m.m, dots 1..4 are m against each corner normal
    // ------------------------------------------------------------------
    logic        [LL_W-1:0]  pll_reg  [NDOT][NAX];
    logic        [LL_W-1:0]  pll_next [NDOT][NAX];
    logic signed [MIX_W-1:0] plh_reg  [NDOT][NAX];
    logic signed [MIX_W-1:0] plh_next [NDOT][NAX];
    logic signed [MIX_W-1:0] phl_reg  [NDOT][NAX];
    logic signed [MIX_W-1:0] phl_next [NDOT][NAX];
    logic signed [HH_W-1:0]  phh_reg  [NDOT][NAX];
    logic signed [HH_W-1:0]  phh_next [NDOT][NAX];

    for (genvar d = 0; d < NDOT; d++)
    begin : g_dot
        for (genvar j = 0; j < NAX; j++)
        begin : g_comp
            logic signed [MW-1:0] rhs;
            logic signed [H:0]    a_lo;
            logic signed [H:0]    b_lo;
            logic signed [HW-1:0] a_hi;
            logic signed [HW-1:0] b_hi;
            if (d == 0)
            begin : g_mag
                assign rhs = m_reg[j];
            end
            else
            begin : g_corner
                assign rhs = w_reg[d - 1][j];
            end
            assign a_lo = {1'b0, m_reg[j][H-1:0]};
            assign b_lo = {1'b0, rhs[H-1:0]};
            assign a_hi = m_reg[j][MW-1:H];
            assign b_hi = rhs[MW-1:H];
            assign pll_next[d][j] = a_lo[H-1:0] * b_lo[H-1:0];
            assign plh_next[d][j] = a_lo * b_hi;
            assign phl_next[d][j] = a_hi * b_lo;
            assign phh_next[d][j] = a_hi * b_hi;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            pll_reg <= pll_next;
            plh_reg <= plh_next;
            phl_reg <= phl_next;
            phh_reg <= phh_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: recombine each axis product
    // ------------------------------------------------------------------
    logic signed [DW-1:0] cp_reg  [NDOT][NAX];
    logic signed [DW-1:0] cp_next [NDOT][NAX];

    for (genvar d = 0; d < NDOT; d++)
    begin : g_comb
        for (genvar j = 0; j < NAX; j++)
        begin : g_comp
            assign cp_next[d][j] = (DW'(phh_reg[d][j]) <<< (2 * H))
                                 + ((DW'(plh_reg[d][j]) + DW'(phl_reg[d][j])) <<< H)
                                 + DW'($signed({1'b0, pll_reg[d][j]}));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            cp_reg <= cp_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: sum over the three axes
    // ------------------------------------------------------------------
    logic signed [SUMW-1:0] dot_reg  [NDOT];
    logic signed [SUMW-1:0] dot_next [NDOT];

    for (genvar d = 0; d < NDOT; d++)
    begin : g_acc
        assign dot_next[d] = SUMW'(cp_reg[d][0]) + SUMW'(cp_reg[d][1])
                           + SUMW'(cp_reg[d][2]);
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            dot_reg <= dot_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 8: tolerance compare, sign agreement, output register
    // ------------------------------------------------------------------
    logic           degen_reg, degen_next;
    logic           inv_reg, inv_next;
    logic [NCD-1:0] pos;
    logic [NCD-1:0] neg;

    for (genvar d = 0; d < NCD; d++)
    begin : g_sign
        assign neg[d] = dot_reg[d + 1][SUMW-1];
        assign pos[d] = !dot_reg[d + 1][SUMW-1] && (dot_reg[d + 1] != '0);
    end

    // m.m is never negative, so its bits compare as unsigned
    assign degen_next = CMPW'($unsigned(dot_reg[0])) <= CMPW'(lim_reg);
    assign inv_next   = !degen_next && ((&pos) || (&neg));

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            degen_reg <= degen_next;
            inv_reg   <= inv_next;
        end
    end

    assign m_tdata = OUTW'({degen_reg, inv_reg});

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// tb: self-checking bench for quad_invertibility_check_top (bilinear quad jacobian sign check)
// depends on qic_pkg and the top level; predicts each verdict with exact 192-bit arithmetic
// drives directed quads, tolerance boundaries and random planar and raw quads under stalls
`default_nettype none

module tb;

    // sizes taken from the shared package
    localparam int NUM_CORNERS     = qic_pkg::NUM_CORNERS;
    localparam int NUM_AXES        = qic_pkg::NUM_AXES;
    localparam int NUM_FIELDS      = qic_pkg::NUM_FIELDS;
    localparam int NUM_CORNER_DOTS = qic_pkg::NUM_CORNER_DOTS;
    localparam int NUM_STAGES      = qic_pkg::NUM_STAGES;
    localparam int TOL_BITS        = qic_pkg::TOL_BITS;
    localparam int APB_DATA_BITS   = qic_pkg::APB_DATA_BITS;
    localparam int APB_ADDR_BITS   = qic_pkg::APB_ADDR_BITS;
    localparam int REG_STRIDE_LOG2 = qic_pkg::REG_STRIDE_LOG2;
    localparam int REG_IDX_BITS    = qic_pkg::REG_IDX_BITS;
    localparam int OUT_TDATA_BITS  = qic_pkg::OUT_TDATA_BITS;
    localparam logic [REG_IDX_BITS-1:0] REG_TOLERANCE = qic_pkg::REG_TOLERANCE;

    localparam int COORD_BITS = qic_pkg::COORD_BITS_DEF;
    localparam int IN_BITS    = ((NUM_FIELDS * COORD_BITS + 7) / 8) * 8;

    // handy coordinate values: one unit in Q12.12 and the field extremes
    localparam int SIDE_LEN = 4096;
    localparam int CMIN     = -(1 << (COORD_BITS - 1));
    localparam int CMAX     = (1 << (COORD_BITS - 1)) - 1;

    // result word layout
    localparam int OUT_INVERTIBLE_BIT = 0;
    localparam int OUT_DEGENERATE_BIT = 1;

    // register map: the tolerance register and an unmapped slot next to it
    localparam logic [REG_IDX_BITS-1:0]  REG_UNMAPPED = 1;
    localparam logic [APB_ADDR_BITS-1:0] TOL_ADDR =
        APB_ADDR_BITS'(REG_TOLERANCE) << REG_STRIDE_LOG2;
    localparam logic [APB_ADDR_BITS-1:0] UNMAPPED_ADDR =
        APB_ADDR_BITS'(REG_UNMAPPED) << REG_STRIDE_LOG2;

    localparam int RANDOM_PER_PHASE = 270;
    localparam int NUM_PHASES       = 5;
    localparam int HOLD_CYCLES      = 300;
    localparam int CYCLE_LIMIT      = 400000;

    // field k = corner*3 + axis, p0_x in the lowest bits
    typedef logic [NUM_FIELDS-1:0][COORD_BITS-1:0] quad_word_t;
    typedef int corner_list_t [NUM_FIELDS];

    // exact wide arithmetic for the predictor
    typedef logic signed [191:0] wide_t;
    typedef struct {
        wide_t x;
        wide_t y;
        wide_t z;
    } wvec_t;

    typedef struct packed {
        logic degenerate_midpoint;
        logic invertible;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_BITS-1:0]       s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;

    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    quad_invertibility_check_top #(
        .COORD_BITS(COORD_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // shared state between stimulus, driver, receiver and monitor
    quad_word_t          quads_to_send[$];
    verdict_t            verdicts_due[$];
    logic [TOL_BITS-1:0] tol_shadow = '0;
    int                  send_idle_pct = 30;
    int                  recv_idle_pct = 30;
    int                  hold_asked = 0;
    int                  hold_served = 0;
    int                  mismatch_count = 0;
    int                  cycle_count = 0;
    int                  results_seen = 0;
    bit                  in_taken = 1'b0;
    bit                  out_taken = 1'b0;

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic wvec_t side_vec(quad_word_t q, int from_c, int to_c);
        wvec_t r;
        r.x = wide_t'($signed(q[to_c * NUM_AXES + 0])) - wide_t'($signed(q[from_c * NUM_AXES + 0]));
        r.y = wide_t'($signed(q[to_c * NUM_AXES + 1])) - wide_t'($signed(q[from_c * NUM_AXES + 1]));
        r.z = wide_t'($signed(q[to_c * NUM_AXES + 2])) - wide_t'($signed(q[from_c * NUM_AXES + 2]));
        return r;
    endfunction

    function automatic wvec_t cross_vec(wvec_t a, wvec_t b);
        wvec_t r;
        r.x = a.y * b.z - a.z * b.y;
        r.y = a.z * b.x - a.x * b.z;
        r.z = a.x * b.y - a.y * b.x;
        return r;
    endfunction

    function automatic wvec_t sum_vec(wvec_t a, wvec_t b);
        wvec_t r;
        r.x = a.x + b.x;
        r.y = a.y + b.y;
        r.z = a.z + b.z;
        return r;
    endfunction

    function automatic wide_t dot_vec(wvec_t a, wvec_t b);
        return a.x * b.x + a.y * b.y + a.z * b.z;
    endfunction

    // verdict for one quad under a given tolerance
    function automatic verdict_t judge_quad(quad_word_t q, logic [TOL_BITS-1:0] tol);
        wvec_t    sides [NUM_CORNERS];
        wvec_t    v1, v2, v3, mid;
        wide_t    corner_j [NUM_CORNER_DOTS];
        wide_t    tol_w, mag, lim;
        logic     all_pos, all_neg;
        verdict_t r;
        for (int k = 0; k < NUM_CORNERS; k++)
            sides[k] = side_vec(q, k, (k + 1) % NUM_CORNERS);
        v1  = cross_vec(sides[3], sides[0]);
        v2  = cross_vec(sides[2], sides[0]);
        v3  = cross_vec(sides[3], sides[1]);
        mid = sum_vec(sum_vec(sum_vec(v1, v1), v2), v3);
        tol_w = '0;
        tol_w[TOL_BITS-1:0] = tol;
        lim = 4 * tol_w * tol_w;
        mag = dot_vec(mid, mid);
        r = '0;
        if (mag <= lim)
        begin
            // midpoint jacobian too small: degenerate, never invertible
            r.degenerate_midpoint = 1'b1;
            return r;
        end
        corner_j[0] = dot_vec(mid, v1);
        corner_j[1] = dot_vec(mid, sum_vec(v1, v3));
        corner_j[2] = dot_vec(mid, sum_vec(v1, v2));
        corner_j[3] = dot_vec(mid, sum_vec(sum_vec(v1, v2), v3));
        all_pos = 1'b1;
        all_neg = 1'b1;
        for (int k = 0; k < NUM_CORNER_DOTS; k++)
        begin
            if (corner_j[k] <= 0)
                all_pos = 1'b0;
            if (corner_j[k] >= 0)
                all_neg = 1'b0;
        end
        r.invertible = all_pos | all_neg;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic quad_word_t quad_of(corner_list_t c);
        quad_word_t q;
        for (int k = 0; k < NUM_FIELDS; k++)
            q[k] = COORD_BITS'(c[k]);
        return q;
    endfunction

    // any 24-bit pattern, leaning on the extremes and zero
    function automatic quad_word_t make_raw_quad();
        quad_word_t q;
        for (int k = 0; k < NUM_FIELDS; k++)
        begin
            case ($urandom_range(0, 7))
                0:       q[k] = COORD_BITS'(CMIN);
                1:       q[k] = COORD_BITS'(CMAX);
                2:       q[k] = '0;
                default: q[k] = COORD_BITS'($urandom);
            endcase
        end
        return q;
    endfunction

    // quad laid out on a small 2D grid and mapped into 3D by two random edge vectors;
    // mostly convex in either winding, sometimes arbitrary, lifted or squashed flat
    function automatic quad_word_t make_planar_quad();
        int         gx [NUM_CORNERS];
        int         gy [NUM_CORNERS];
        longint     org [NUM_AXES];
        longint     u [NUM_AXES];
        longint     w [NUM_AXES];
        longint     h [NUM_AXES];
        longint     c;
        int         scale, shape, a, b, t;
        bit         lift;
        quad_word_t q;
        scale = $urandom_range(2, 17);
        for (int ax = 0; ax < NUM_AXES; ax++)
        begin
            org[ax] = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
            u[ax]   = longint'($urandom_range(0, 2 << scale)) - (1 << scale);
            w[ax]   = longint'($urandom_range(0, 2 << scale)) - (1 << scale);
            h[ax]   = longint'($urandom_range(0, 2 << scale)) - (1 << scale);
        end
        shape = $urandom_range(0, 9);
        a = $urandom_range(2, 6);
        b = $urandom_range(2, 6);
        gx = '{0, a, a, 0};
        gy = '{0, 0, b, b};
        if (shape < 6)
        begin
            // convex with a little jitter, half of them wound the other way
            for (int k = 0; k < NUM_CORNERS; k++)
            begin
                gx[k] += $urandom_range(0, 2) - 1;
                gy[k] += $urandom_range(0, 2) - 1;
            end
            if (shape[0])
            begin
                t = gx[1]; gx[1] = gx[3]; gx[3] = t;
                t = gy[1]; gy[1] = gy[3]; gy[3] = t;
            end
        end
        else if (shape < 9)
        begin
            for (int k = 0; k < NUM_CORNERS; k++)
            begin
                gx[k] = $urandom_range(0, 12) - 6;
                gy[k] = $urandom_range(0, 12) - 6;
            end
        end
        else
        begin
            // all corners on one line
            for (int k = 0; k < NUM_CORNERS; k++)
                gy[k] = 0;
        end
        lift = ($urandom_range(0, 2) == 0);
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            for (int ax = 0; ax < NUM_AXES; ax++)
            begin
                c = org[ax] + gx[k] * u[ax] + gy[k] * w[ax];
                if (lift && k == 2)
                    c += h[ax];
                q[k * NUM_AXES + ax] = COORD_BITS'(c);
            end
        end
        return q;
    endfunction

    function automatic int draw_wait(int pct);
        if ($urandom_range(0, 99) < pct)
            return $urandom_range(1, 14);
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------

    task automatic reg_write(input logic [APB_ADDR_BITS-1:0] addr,
                             input logic [APB_DATA_BITS-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (REG_IDX_BITS'(addr >> REG_STRIDE_LOG2) == REG_TOLERANCE)
            tol_shadow = value[TOL_BITS-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_check_tolerance();
        logic [APB_DATA_BITS-1:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= TOL_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        if (got !== APB_DATA_BITS'(tol_shadow))
            report_mismatch($sformatf("tolerance reads %h, expected %h", got, tol_shadow));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // block is idle once nothing waits to be sent or checked and the pipe has flushed
    task automatic wait_drained();
        do @(posedge clk);
        while (quads_to_send.size() != 0 || s_tvalid || verdicts_due.size() != 0);
        repeat (NUM_STAGES + 4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // input driver: offers one word at a time, random gap before each new one
    // ------------------------------------------------------------------
    int send_wait = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || in_taken)
        begin
            if (send_wait > 0)
            begin
                send_wait--;
                s_tvalid <= 1'b0;
            end
            else if (quads_to_send.size() != 0)
            begin
                s_tdata   <= IN_BITS'(quads_to_send.pop_front());
                s_tvalid  <= 1'b1;
                send_wait = draw_wait(send_idle_pct);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // result receiver: random stall after each word, plus the long hold-off
    // ------------------------------------------------------------------
    int recv_wait = 0;
    int hold_left = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (hold_asked != hold_served)
            begin
                hold_left   = HOLD_CYCLES;
                hold_served = hold_asked;
            end
            if (out_taken)
                recv_wait = draw_wait(recv_idle_pct);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // monitor: predicts on input acceptance, checks on output acceptance
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        verdict_t want;
        in_taken  = 1'b0;
        out_taken = 1'b0;
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("tb: done, errors");
                $finish;
            end
            if (s_tvalid && s_tready)
            begin
                in_taken = 1'b1;
                verdicts_due.push_back(judge_quad(quad_word_t'(s_tdata), tol_shadow));
            end
            if (m_tvalid && m_tready)
            begin
                out_taken = 1'b1;
                if (verdicts_due.size() == 0)
                    report_mismatch($sformatf("result word %0d with nothing pending",
                                              results_seen));
                else
                begin
                    want = verdicts_due.pop_front();
                    if (m_tdata[OUT_INVERTIBLE_BIT] !== want.invertible)
                        report_mismatch($sformatf("word %0d invertible %b, expected %b",
                            results_seen, m_tdata[OUT_INVERTIBLE_BIT], want.invertible));
                    if (m_tdata[OUT_DEGENERATE_BIT] !== want.degenerate_midpoint)
                        report_mismatch($sformatf("word %0d degenerate %b, expected %b",
                            results_seen, m_tdata[OUT_DEGENERATE_BIT],
                            want.degenerate_midpoint));
                end
                results_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [APB_DATA_BITS-1:0] tol_value;
        quad_word_t               unit_square;
        quad_word_t               tiny_square;

        unit_square = quad_of('{0, 0, 0, SIDE_LEN, 0, 0, SIDE_LEN, SIDE_LEN, 0,
                                0, SIDE_LEN, 0});
        tiny_square = quad_of('{0, 0, 0, 1, 0, 0, 1, 1, 0, 0, 1, 0});

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // tolerance comes out of reset as zero
        reg_check_tolerance();

        // directed quads at zero tolerance
        quads_to_send.push_back(quad_of('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}));
        quads_to_send.push_back(unit_square);
        // same square wound clockwise: all corner values negative
        quads_to_send.push_back(quad_of('{0, 0, 0, 0, SIDE_LEN, 0, SIDE_LEN, SIDE_LEN, 0,
                                          SIDE_LEN, 0, 0}));
        // bow-tie
        quads_to_send.push_back(quad_of('{0, 0, 0, SIDE_LEN, 0, 0, 0, SIDE_LEN, 0,
                                          SIDE_LEN, SIDE_LEN, 0}));
        // concave dart
        quads_to_send.push_back(quad_of('{0, 0, 0, 4 * SIDE_LEN, 0, 0, SIDE_LEN, SIDE_LEN, 0,
                                          0, 4 * SIDE_LEN, 0}));
        // full-range squares, largest sides the fields allow
        quads_to_send.push_back(quad_of('{CMIN, CMIN, 0, CMAX, CMIN, 0, CMAX, CMAX, 0,
                                          CMIN, CMAX, 0}));
        quads_to_send.push_back(quad_of('{0, CMIN, CMIN, 0, CMIN, CMAX, 0, CMAX, CMAX,
                                          0, CMAX, CMIN}));
        quads_to_send.push_back(quad_of('{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
                                          CMAX, CMAX, CMAX}));
        quads_to_send.push_back(quad_of('{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                                          CMIN, CMIN, CMIN}));
        quads_to_send.push_back(quad_of('{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN,
                                          CMIN, CMIN, CMAX}));
        // last corner on top of the first: a triangle, one corner value is zero
        quads_to_send.push_back(quad_of('{0, 0, 0, SIDE_LEN, 0, 0, SIDE_LEN, SIDE_LEN, 0,
                                          0, 0, 0}));
        // collinear corners
        quads_to_send.push_back(quad_of('{0, 0, 0, SIDE_LEN, SIDE_LEN, SIDE_LEN,
                                          2 * SIDE_LEN, 2 * SIDE_LEN, 2 * SIDE_LEN,
                                          3 * SIDE_LEN, 3 * SIDE_LEN, 3 * SIDE_LEN}));
        // mild and strong saddles
        quads_to_send.push_back(quad_of('{0, 0, 0, SIDE_LEN, 0, 0, SIDE_LEN, SIDE_LEN, SIDE_LEN,
                                          0, SIDE_LEN, 0}));
        quads_to_send.push_back(quad_of('{0, 0, -8 * SIDE_LEN, SIDE_LEN, 0, 8 * SIDE_LEN,
                                          SIDE_LEN, SIDE_LEN, -8 * SIDE_LEN,
                                          0, SIDE_LEN, 8 * SIDE_LEN}));
        // smallest square that is not degenerate at zero tolerance
        quads_to_send.push_back(tiny_square);
        wait_drained();

        // tolerance right at the unit square's midpoint jacobian: degenerate;
        // junk above bit 47 must be dropped
        reg_write(TOL_ADDR, 64'hA5A5_0000_0000_0000 | (64'(SIDE_LEN) * SIDE_LEN));
        reg_check_tolerance();
        quads_to_send.push_back(unit_square);
        quads_to_send.push_back(tiny_square);
        wait_drained();

        // one below the boundary: invertible again
        reg_write(TOL_ADDR, 64'(SIDE_LEN) * SIDE_LEN - 1);
        reg_check_tolerance();
        quads_to_send.push_back(unit_square);
        wait_drained();

        // writes to the unmapped slot leave the tolerance alone
        reg_write(UNMAPPED_ADDR, '1);
        reg_check_tolerance();
        quads_to_send.push_back(unit_square);
        wait_drained();

        // tolerance of one least bit sits exactly on the tiny square
        reg_write(TOL_ADDR, 64'd1);
        reg_check_tolerance();
        quads_to_send.push_back(tiny_square);
        quads_to_send.push_back(unit_square);

        // random phases, each with its own tolerance and idling mix
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drained();
            case (ph)
                0:
                begin
                    tol_value     = '0;
                    send_idle_pct = 30;
                    recv_idle_pct = 30;
                end
                1:
                begin
                    // largest tolerance, no idling on either side
                    tol_value     = 64'hFFFF_FFFF_FFFF;
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                2:
                begin
                    tol_value     = 64'({$urandom_range(1, 255), 20'h0}) << $urandom_range(0, 12);
                    send_idle_pct = 10;
                    recv_idle_pct = 20;
                end
                3:
                begin
                    tol_value     = {$urandom, $urandom};
                    send_idle_pct = 10;
                    recv_idle_pct = 70;
                end
                default:
                begin
                    tol_value     = 64'($urandom) << $urandom_range(0, 10);
                    send_idle_pct = 50;
                    recv_idle_pct = 50;
                end
            endcase
            reg_write(TOL_ADDR, tol_value);
            reg_check_tolerance();
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if ($urandom_range(0, 99) < 55)
                    quads_to_send.push_back(make_planar_quad());
                else
                    quads_to_send.push_back(make_raw_quad());
            end
            // long receiver hold-off while the sender keeps offering: pipe fills and
            // the input side has to stall
            if (ph == 2)
            begin
                @(posedge clk);
                hold_asked++;
            end
        end
        wait_drained();

        if (mismatch_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
